[hw/rtl/assert_macros.svh]
// assertion helpers, clocked on clk_i and disabled while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define FLQ_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define FLQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hw/rtl/flq_pkg.sv]
// ---------------------------------------------------------------------------
// flq_pkg
// Types and constants shared by the fixed latency load queue.
// ---------------------------------------------------------------------------
`default_nettype none

package flq_pkg;

  localparam int LATENCY_W  = 8;
  localparam int DCNT_W     = 4;
  localparam int TAG_W      = 16;
  localparam int DREG_W     = 8;
  localparam int DATA_W     = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam int QUEUE_DEPTH_DEF = 16;

  localparam logic [LATENCY_W-1:0] LATENCY_RST  = 8'd4;
  localparam logic                 ATTACHED_RST = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LATENCY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACHED = 2'd1;

  // request kinds
  localparam logic REQ_ISSUE = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic              pipe_is_global;
    logic              is_memory_op;
    logic [DCNT_W-1:0] dest_count;
    logic [TAG_W-1:0]  instr_tag;
    logic [DREG_W-1:0] dest_reg;
    logic [DATA_W-1:0] load_data;
  } item_t;

  typedef struct packed {
    logic [LATENCY_W-1:0] lat;
    logic [TAG_W-1:0]     tag;
    logic [DREG_W-1:0]    dreg;
    logic [DATA_W-1:0]    data;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [LATENCY_W-1:0] eff_latency;
    logic                 attached;
  } cfg_t;

  typedef struct packed {
    logic                 valid;
    logic [LATENCY_W-1:0] issue_latency;
    logic                 queue_full;
    logic                 wb_valid;
    logic [DREG_W-1:0]    wb_reg;
    logic [DATA_W-1:0]    wb_data;
    logic [TAG_W-1:0]     done_tag;
  } res_t;

endpackage

`default_nettype wire

[hw/rtl/fixed_latency_load_queue.sv]
// ---------------------------------------------------------------------------
// fixed_latency_load_queue
// Global load unit: queues issued loads and completes them on ticks.
// ---------------------------------------------------------------------------
// One request (issue or tick) is taken in every cycle in which start is high
// and busy is low; busy is high only in the first cycle after reset. Each
// request gives exactly one result word on the result ports, marked by done_o
// for one cycle; the receiver cannot stall, so results must be consumed when
// shown.
// A request passes the input register, one pass of queue logic and the result
// register, with the head entry read ahead from the entry RAM.
// No clearing pass is needed after reset.
`default_nettype none

module fixed_latency_load_queue
  import flq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic                  req_type_i,
  input  wire logic                  pipe_is_global_i,
  input  wire logic                  is_memory_op_i,
  input  wire logic [DCNT_W-1:0]     dest_count_i,
  input  wire logic [TAG_W-1:0]      instr_tag_i,
  input  wire logic [DREG_W-1:0]     dest_reg_i,
  input  wire logic [DATA_W-1:0]     load_data_i,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                       done_o,
  output logic [LATENCY_W-1:0]       issue_latency_o,
  output logic                       queue_full_o,
  output logic                       wb_valid_o,
  output logic [DREG_W-1:0]          wb_reg_o,
  output logic [DATA_W-1:0]          wb_data_o,
  output logic [TAG_W-1:0]           done_tag_o
);

  logic  busy_q;
  logic  vld_q;
  item_t item_q;
  cfg_t  cfg;
  res_t  res;
  logic  take;

  assign busy = busy_q;
  assign take = start && !busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      vld_q  <= 1'b0;
    end else begin
      busy_q <= 1'b0;
      vld_q  <= take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q.req_type       <= req_type_i;
      item_q.pipe_is_global <= pipe_is_global_i;
      item_q.is_memory_op   <= is_memory_op_i;
      item_q.dest_count     <= dest_count_i;
      item_q.instr_tag      <= instr_tag_i;
      item_q.dest_reg       <= dest_reg_i;
      item_q.load_data      <= load_data_i;
    end
  end

  flq_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  flq_core #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (vld_q),
    .item_i       (item_q),
    .cfg_i        (cfg),
    .res_o        (res)
  );

  assign done_o          = res.valid;
  assign issue_latency_o = res.issue_latency;
  assign queue_full_o    = res.queue_full;
  assign wb_valid_o      = res.wb_valid;
  assign wb_reg_o        = res.wb_reg;
  assign wb_data_o       = res.wb_data;
  assign done_tag_o      = res.done_tag;

`include "assert_macros.svh"

  `FLQ_ASSERT_NEXT(a_taken_word_gives_result, vld_q, done_o)
  `FLQ_ASSERT_NEXT(a_no_word_no_result, !vld_q, !done_o)
  `FLQ_ASSERT_IMPL(a_writeback_only_on_tick, done_o && wb_valid_o,
                   issue_latency_o == '0 && !queue_full_o)
  `FLQ_ASSERT_IMPL(a_full_has_no_latency, done_o && queue_full_o,
                   issue_latency_o == '0 && !wb_valid_o)

endmodule

`default_nettype wire

[hw/rtl/flq_ram.sv]
// ---------------------------------------------------------------------------
// flq_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module flq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

[hw/rtl/flq_cfg.sv]
// ---------------------------------------------------------------------------
// flq_cfg
// Configuration registers: latency and attached flag.
// ---------------------------------------------------------------------------
`default_nettype none

module flq_cfg
  import flq_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                       cfg_o
);

  logic [LATENCY_W-1:0] latency_q;
  logic                 attached_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latency_q  <= LATENCY_RST;
      attached_q <= ATTACHED_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LATENCY:  latency_q  <= cfg_data_i[LATENCY_W-1:0];
        CFG_ATTACHED: attached_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // a cleared latency register gives the smallest nonzero effective latency
  assign cfg_o.eff_latency = (latency_q == '0) ? LATENCY_W'(1) : latency_q;
  assign cfg_o.attached    = attached_q;

endmodule

`default_nettype wire

[hw/rtl/flq_core.sv]
// ---------------------------------------------------------------------------
// flq_core
// Queue pointers, entry storage, head countdown and the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module flq_core
  import flq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic item_valid_i,
  input  item_t     item_i,
  input  cfg_t      cfg_i,
  output res_t      res_o
);

  logic [PTR_W-1:0]     head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [LATENCY_W-1:0] cnt_q, cnt_d;
  logic                 fresh_q, fresh_d;
  logic                 byp_q, byp_d;
  entry_t               byp_word_q;
  entry_t               wr_word;
  logic                 wr_en;
  logic [ENTRY_W-1:0]   rdata;
  entry_t               head_word;
  logic [LATENCY_W-1:0] cur_cnt, dec_cnt;
  logic                 issue_ok;
  res_t                 res_d;

  flq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (tail_q),
    .wdata_i (wr_word),
    .raddr_i (head_d),
    .rdata_o (rdata)
  );

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  // a word written into an empty queue is its head before the ram read sees it
  assign head_word = byp_q ? byp_word_q : entry_t'(rdata);
  // fresh: head just changed, its countdown is still the stored one
  assign cur_cnt   = fresh_q ? head_word.lat : cnt_q;
  assign dec_cnt   = (cur_cnt == '0) ? '0 : cur_cnt - LATENCY_W'(1);
  assign issue_ok  = cfg_i.attached && item_i.pipe_is_global && item_i.is_memory_op &&
                     (item_i.dest_count != '0);

  assign wr_word.lat  = cfg_i.eff_latency;
  assign wr_word.tag  = item_i.instr_tag;
  assign wr_word.dreg = item_i.dest_reg;
  assign wr_word.data = item_i.load_data;

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    cnt_d   = cnt_q;
    fresh_d = fresh_q;
    wr_en   = 1'b0;
    res_d   = '0;
    res_d.valid = item_valid_i;
    if (item_valid_i) begin
      if (item_i.req_type == REQ_ISSUE) begin
        if (issue_ok) begin
          if (count_q == CNT_W'(QUEUE_DEPTH)) begin
            res_d.queue_full = 1'b1;
          end else begin
            wr_en   = 1'b1;
            tail_d  = ptr_inc(tail_q);
            count_d = count_q + CNT_W'(1);
            res_d.issue_latency = cfg_i.eff_latency;
            if (count_q == '0) begin
              fresh_d = 1'b1;
            end
          end
        end
      end else if (count_q != '0) begin
        if (dec_cnt == '0) begin
          res_d.wb_valid = 1'b1;
          res_d.wb_reg   = head_word.dreg;
          res_d.wb_data  = head_word.data;
          res_d.done_tag = head_word.tag;
          head_d  = ptr_inc(head_q);
          count_d = count_q - CNT_W'(1);
          fresh_d = 1'b1;
        end else begin
          cnt_d   = dec_cnt;
          fresh_d = 1'b0;
        end
      end
    end
    byp_d = wr_en && (tail_q == head_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      cnt_q   <= '0;
      fresh_q <= 1'b0;
      byp_q   <= 1'b0;
      res_o   <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      cnt_q   <= cnt_d;
      fresh_q <= fresh_d;
      byp_q   <= byp_d;
      res_o   <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byp_word_q <= wr_word;
  end

endmodule

`default_nettype wire
